/* hw/rtl/lpcp_pkg.sv */
package lpcp_pkg;

    localparam int LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    localparam int NAME_COUNT = 6;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_PITCH    = 3'd1,
        CMD_ROLL     = 3'd2,
        CMD_THROTTLE = 3'd3,
        CMD_YAW      = 3'd4,
        CMD_POWER    = 3'd5,
        CMD_MOTOR    = 3'd6
    } cmd_t;

    // Names left-justified, zero padded to eight bytes; order follows command codes.
    localparam logic [63:0] NAME_TEXT [NAME_COUNT] = '{
        {"pitch", 24'h0},
        {"roll", 32'h0},
        "throttle",
        {"yaw", 40'h0},
        {"power", 24'h0},
        {"motor", 24'h0}
    };
    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{4'd5, 4'd4, 4'd8, 4'd3, 4'd5, 4'd5};

    localparam logic [7:0] CHAR_START = "!";
    localparam logic [7:0] CHAR_BEAT  = "b";

    localparam logic signed [15:0] CENTER_RESET   = 16'sd1500;
    localparam logic signed [15:0] THROTTLE_RESET = 16'sd1000;

    typedef struct packed {
        logic [NAME_COUNT-1:0] mask;
        cmd_t                  code;
    } name_match_t;

endpackage

/* hw/rtl/length_prefixed_command_parser.sv */
// Each accepted input transaction is held in the input register; its per-byte state
// update moves it into the result register. One byte per cycle while the result is not
// stalled (out_stall low or no result pending).
// A stalled result does not block intake while the input register is free.
// Reset (rst_n low, asynchronous): parser idle, pitch/roll/yaw 1500, throttle 1000,
// power off, no transaction pending on either side.
module length_prefixed_command_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pitch_value,
    output logic signed [15:0] roll_value,
    output logic signed [15:0] yaw_value,
    output logic signed [15:0] throttle_value,
    output logic               power_on,
    output logic               heartbeat_seen,
    output logic [2:0]         updated_field
);

    localparam int LB = lpcp_pkg::LEN_BITS;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NLEN,
        PH_NAME,
        PH_VLEN,
        PH_VLEAD,
        PH_VDIG
    } phase_t;

    // handshake / input stage
    logic       in_valid_reg;
    logic       action_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic       out_can;
    logic       step;
    logic       in_take;

    // parser state
    phase_t                          phase_reg, phase_next;
    logic [LB-1:0]                   len_reg, len_next;
    logic [LB-1:0]                   pos_reg, pos_next;
    logic [lpcp_pkg::NAME_COUNT-1:0] mask_reg, mask_next;
    lpcp_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [16:0]                     acc_reg, acc_next;
    logic                            neg_reg, neg_next;
    logic                            stop_reg, stop_next;
    logic                            on_reg, on_next;
    logic signed [15:0]              pitch_reg, pitch_next;
    logic signed [15:0]              roll_reg, roll_next;
    logic signed [15:0]              yaw_reg, yaw_next;
    logic signed [15:0]              throttle_reg, throttle_next;
    logic                            power_reg, power_next;
    logic                            hb_reg, hb_next;
    lpcp_pkg::cmd_t                  done_reg, done_next;

    // per-byte datapath
    logic                  is_digit;
    logic                  is_blank;
    logic [3:0]            dval;
    logic [LB+3:0]         len_prod;
    logic [LB-1:0]         len_sat;
    logic [LB-1:0]         pos_inc;
    logic                  last_byte;
    logic [18:0]           acc_prod;
    logic [16:0]           acc_sat;
    logic [16:0]           vacc;
    logic                  vneg;
    logic                  vstop;
    logic                  von;
    logic signed [15:0]    vres;
    logic                  finish;
    logic                  fin_has;
    logic signed [15:0]    fin_val;
    logic                  go_idle;
    logic                  start;
    lpcp_pkg::name_match_t nm;

    assign out_can  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_can;
    assign in_stall = in_valid_reg && !out_can;
    assign in_take  = in_valid && !in_stall;

    lpcp_name_match u_name_match (
        .byte_position (pos_reg),
        .length_count  (len_reg),
        .rx_char       (byte_reg),
        .mask_in       (mask_reg),
        .result        (nm)
    );

    assign is_digit  = (byte_reg >= "0") && (byte_reg <= "9");
    assign is_blank  = (byte_reg == 8'h20) || ((byte_reg >= 8'h09) && (byte_reg <= 8'h0D));
    assign dval      = 4'(byte_reg - "0");
    assign len_prod  = {4'd0, len_reg} * (LB+4)'(10) + {{LB{1'b0}}, dval};
    assign len_sat   = (len_prod > {4'd0, lpcp_pkg::LEN_MAX}) ? lpcp_pkg::LEN_MAX
                                                              : len_prod[LB-1:0];
    assign pos_inc   = pos_reg + {{(LB-1){1'b0}}, 1'b1};
    assign last_byte = pos_inc >= len_reg;
    assign acc_prod  = {2'd0, acc_reg} * 19'd10 + {15'd0, dval};
    assign acc_sat   = (acc_prod > 19'd32768) ? 17'd32768 : acc_prod[16:0];

    // value byte: atoi-style scan
    always_comb
    begin
        vacc  = acc_reg;
        vneg  = neg_reg;
        vstop = stop_reg;
        von   = on_reg && ((pos_reg == '0 && byte_reg == "o") ||
                           (pos_reg == {{(LB-1){1'b0}}, 1'b1} && byte_reg == "n"));
        if (phase_reg == PH_VLEAD)
        begin
            if (is_blank)
            begin
                vacc = acc_reg;
            end
            else if (byte_reg == "+" || byte_reg == "-")
            begin
                vneg = (byte_reg == "-");
            end
            else if (is_digit)
            begin
                vacc = {13'd0, dval};
            end
            else
            begin
                vstop = 1'b1;
            end
        end
        else if (!stop_reg)
        begin
            if (is_digit)
                vacc = acc_sat;
            else
                vstop = 1'b1;
        end

        if (vneg)
            vres = (vacc >= 17'd32768) ? 16'sh8000 : 16'(~vacc[15:0] + 16'd1);
        else
            vres = (vacc >= 17'd32767) ? 16'sh7FFF : vacc[15:0];
    end

    always_comb
    begin
        phase_next    = phase_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        mask_next     = mask_reg;
        cmd_next      = cmd_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        stop_next     = stop_reg;
        on_next       = on_reg;
        pitch_next    = pitch_reg;
        roll_next     = roll_reg;
        yaw_next      = yaw_reg;
        throttle_next = throttle_reg;
        power_next    = power_reg;
        hb_next       = 1'b0;
        done_next     = lpcp_pkg::CMD_NONE;
        finish        = 1'b0;
        fin_has       = 1'b0;
        go_idle       = 1'b0;
        start         = 1'b0;

        if (action_reg)
        begin
            power_next = 1'b0;
            go_idle    = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (byte_reg == lpcp_pkg::CHAR_START)
                    begin
                        go_idle = 1'b1;
                        start   = 1'b1;
                    end
                    else if (byte_reg == lpcp_pkg::CHAR_BEAT)
                    begin
                        hb_next = 1'b1;
                    end
                end
                PH_NLEN:
                begin
                    if (is_digit)
                    begin
                        len_next = len_sat;
                    end
                    else if (len_reg == '0)
                    begin
                        go_idle = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                        pos_next   = '0;
                        mask_next  = '1;
                    end
                end
                PH_NAME:
                begin
                    mask_next = nm.mask;
                    pos_next  = pos_inc;
                    if (last_byte)
                    begin
                        if (nm.code == lpcp_pkg::CMD_NONE)
                        begin
                            go_idle = 1'b1;
                        end
                        else
                        begin
                            cmd_next   = nm.code;
                            phase_next = PH_VLEN;
                            len_next   = '0;
                            pos_next   = '0;
                        end
                    end
                end
                PH_VLEN:
                begin
                    if (is_digit)
                    begin
                        len_next = len_sat;
                    end
                    else if (len_reg == '0)
                    begin
                        // empty value completes on the separator
                        finish  = 1'b1;
                        go_idle = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_VLEAD;
                        pos_next   = '0;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        stop_next  = 1'b0;
                        on_next    = 1'b1;
                    end
                end
                PH_VLEAD, PH_VDIG:
                begin
                    acc_next   = vacc;
                    neg_next   = vneg;
                    stop_next  = vstop;
                    on_next    = von;
                    pos_next   = pos_inc;
                    phase_next = PH_VDIG;
                    if (phase_reg == PH_VLEAD && is_blank)
                        phase_next = PH_VLEAD;
                    if (last_byte)
                    begin
                        finish  = 1'b1;
                        fin_has = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase
        end

        fin_val = fin_has ? vres : 16'sd0;
        if (finish)
        begin
            done_next = cmd_reg;
            case (cmd_reg)
                lpcp_pkg::CMD_PITCH:
                begin
                    if (fin_has)
                        pitch_next = fin_val;
                end
                lpcp_pkg::CMD_ROLL:
                begin
                    if (fin_has)
                        roll_next = fin_val;
                end
                lpcp_pkg::CMD_THROTTLE: throttle_next = fin_val;
                lpcp_pkg::CMD_YAW:      yaw_next = fin_val;
                lpcp_pkg::CMD_POWER:
                begin
                    throttle_next = lpcp_pkg::THROTTLE_RESET;
                    power_next    = fin_has && von && (len_reg == LB'(2));
                end
                default:
                begin
                    power_next = power_next;
                end
            endcase
        end

        if (go_idle)
        begin
            phase_next = PH_IDLE;
            len_next   = '0;
            pos_next   = '0;
            mask_next  = '1;
            cmd_next   = lpcp_pkg::CMD_NONE;
            acc_next   = '0;
            neg_next   = 1'b0;
            stop_next  = 1'b0;
            on_next    = 1'b0;
        end
        if (start)
            phase_next = PH_NLEN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            action_reg    <= 1'b0;
            byte_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            len_reg       <= '0;
            pos_reg       <= '0;
            mask_reg      <= '1;
            cmd_reg       <= lpcp_pkg::CMD_NONE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            on_reg        <= 1'b0;
            pitch_reg     <= lpcp_pkg::CENTER_RESET;
            roll_reg      <= lpcp_pkg::CENTER_RESET;
            yaw_reg       <= lpcp_pkg::CENTER_RESET;
            throttle_reg  <= lpcp_pkg::THROTTLE_RESET;
            power_reg     <= 1'b0;
            hb_reg        <= 1'b0;
            done_reg      <= lpcp_pkg::CMD_NONE;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
                action_reg   <= action;
                byte_reg     <= rx_byte;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            out_valid_reg <= step || (out_valid_reg && out_stall);

            // state advances only when a transaction moves into the result register,
            // so the state registers always mirror the result on offer
            if (step)
            begin
                phase_reg    <= phase_next;
                len_reg      <= len_next;
                pos_reg      <= pos_next;
                mask_reg     <= mask_next;
                cmd_reg      <= cmd_next;
                acc_reg      <= acc_next;
                neg_reg      <= neg_next;
                stop_reg     <= stop_next;
                on_reg       <= on_next;
                pitch_reg    <= pitch_next;
                roll_reg     <= roll_next;
                yaw_reg      <= yaw_next;
                throttle_reg <= throttle_next;
                power_reg    <= power_next;
                hb_reg       <= hb_next;
                done_reg     <= done_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign pitch_value    = pitch_reg;
    assign roll_value     = roll_reg;
    assign yaw_value      = yaw_reg;
    assign throttle_value = throttle_reg;
    assign power_on       = power_reg;
    assign heartbeat_seen = hb_reg;
    assign updated_field  = done_reg;

    a_hb_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (updated_field != lpcp_pkg::CMD_NONE) |-> !heartbeat_seen)
        else $error("heartbeat and command completion in one transaction");

    a_link_lost: assert property (@(posedge clk) disable iff (!rst_n)
        step && action_reg |=> !power_on && (phase_reg == PH_IDLE))
        else $error("link lost did not clear power and parser");

    a_power_throttle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (updated_field == lpcp_pkg::CMD_POWER) |-> (throttle_value == 16'sd1000))
        else $error("power command left throttle off its default");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(power_reg) && $stable(pitch_reg))
        else $error("parser state moved without a transaction");

endmodule

/* hw/rtl/lpcp_name_match.sv */
module lpcp_name_match (
    input  logic [lpcp_pkg::LEN_BITS-1:0]   byte_position,
    input  logic [lpcp_pkg::LEN_BITS-1:0]   length_count,
    input  logic [7:0]                      rx_char,
    input  logic [lpcp_pkg::NAME_COUNT-1:0] mask_in,
    output lpcp_pkg::name_match_t           result
);

    logic [lpcp_pkg::NAME_COUNT-1:0] mask;
    lpcp_pkg::cmd_t                  code;

    always_comb
    begin
        mask = mask_in;
        code = lpcp_pkg::CMD_NONE;
        for (int i = 0; i < lpcp_pkg::NAME_COUNT; i++)
        begin
            if (byte_position >= {{(lpcp_pkg::LEN_BITS-4){1'b0}}, lpcp_pkg::NAME_LEN[i]} ||
                lpcp_pkg::NAME_TEXT[i][63 - 8*byte_position[2:0] -: 8] != rx_char)
            begin
                mask[i] = 1'b0;
            end
        end
        // names are distinct, so at most one survives with the right length
        for (int i = 0; i < lpcp_pkg::NAME_COUNT; i++)
        begin
            if (mask[i] &&
                {{(lpcp_pkg::LEN_BITS-4){1'b0}}, lpcp_pkg::NAME_LEN[i]} == length_count)
            begin
                code = lpcp_pkg::cmd_t'(3'(i + 1));
            end
        end
    end

    assign result.mask = mask;
    assign result.code = code;

endmodule
